// ===== rtl/rgl_pkg.sv =====
package rgl_pkg;

   // Operation codes on the request channel
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_PIXEL = 1'b1;

   // Correction mode register codes
   localparam logic MODE_VALUE       = 1'b0;
   localparam logic MODE_PER_CHANNEL = 1'b1;
   localparam logic MODE_RESET       = MODE_PER_CHANNEL;

   localparam int LEVEL_W   = 8;
   localparam int TABLE_DEPTH = 256;
   localparam int PROD_W    = 2 * LEVEL_W;
   // Reciprocal scale: q = (x * ceil(2^SHIFT / m)) >> SHIFT is exact for x < 2^16, m < 256
   localparam int RECIP_SHIFT = PROD_W + LEVEL_W;
   localparam int RECIP_W     = RECIP_SHIFT + 1;

   typedef logic [LEVEL_W-1:0] level_type;
   typedef logic [RECIP_W-1:0] recip_type;
   typedef recip_type recip_table_type [TABLE_DEPTH];

   // Pixel fields carried from the table read stage to the scaler
   typedef struct packed {
      logic       per_channel;
      level_type  red;
      level_type  green;
      level_type  blue;
      level_type  alpha;
      level_type  max_level;
      recip_type  recip;
   } pix_type;

   // Reciprocal table built at elaboration by shift-subtract long division
   function automatic recip_table_type build_recip();
      recip_table_type tbl;
      recip_type       quo;
      logic [LEVEL_W:0] rem;
      recip_type       dividend;
      tbl[0] = '0;
      for (int m = 1; m < TABLE_DEPTH; m++) begin
         rem      = '0;
         quo      = '0;
         dividend = recip_type'(1) << RECIP_SHIFT;
         for (int i = RECIP_W - 1; i >= 0; i--) begin
            rem = {rem[LEVEL_W-1:0], dividend[i]};
            if (rem >= (LEVEL_W + 1)'(m)) begin
               rem    = rem - (LEVEL_W + 1)'(m);
               quo[i] = 1'b1;
            end
         end
         if (rem != '0) begin
            quo = quo + recip_type'(1);
         end
         tbl[m] = quo;
      end
      return tbl;
   endfunction

   localparam recip_table_type RECIP_TABLE = build_recip();

endpackage

// ===== rtl/rgb_gamma_lut_correct.sv =====
// RGBA gamma correction through a 256-entry, 8-bit level table. A request with
// op = 0 writes one table entry and returns nothing; op = 1 corrects one pixel and
// returns one response. csr mode 1 (reset) maps red, green and blue through the
// table; mode 0 keeps hue and replaces the HSV value: with m = max(r,g,b) and
// L = table[m], each channel becomes floor(c*L/m), or L when m is 0. Alpha passes.
// One transaction is taken every clock unless an unaccepted response stalls the
// pipeline; a pixel passes table read, multiply, reciprocal multiply and output register.
// The table is held in three identical RAM copies so a pixel reads three entries
// per clock; a write is visible to the next pixel. Entries read before being
// written return undefined levels. Write mode only while the block is idle.
module rgb_gamma_lut_correct import rgl_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      csr_wr_en,
   input  logic      csr_wr_data,
   input  logic      req_valid,
   output logic      req_ready,
   input  logic      req_op,
   input  level_type req_entry_index,
   input  level_type req_entry_level,
   input  level_type req_pixel_red,
   input  level_type req_pixel_green,
   input  level_type req_pixel_blue,
   input  level_type req_pixel_alpha,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   output level_type rsp_out_red,
   output level_type rsp_out_green,
   output level_type rsp_out_blue,
   output level_type rsp_out_alpha
);

   logic      mode_ff, mode_in;
   logic      adv, accept, tbl_wr, tbl_rd;
   level_type max_rg, max_level, addr_red;
   level_type lvl_red, lvl_green, lvl_blue;
   logic      s1_valid_ff, s1_valid_in;
   pix_type   s1_ff, s1_in;

   // Mode register
   assign mode_in = csr_wr_en ? csr_wr_data : mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_RESET;
      end else begin
         mode_ff <= mode_in;
      end
   end

   // Whole pipeline advances when the output register is free or drained
   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv && !reset;
   assign accept    = req_valid && req_ready;
   assign tbl_wr    = accept && (req_op == OP_WRITE);
   assign tbl_rd    = accept && (req_op == OP_PIXEL);

   // HSV value and table addresses
   assign max_rg    = (req_pixel_red > req_pixel_green) ? req_pixel_red : req_pixel_green;
   assign max_level = (max_rg > req_pixel_blue) ? max_rg : req_pixel_blue;
   assign addr_red  = (mode_ff == MODE_PER_CHANNEL) ? req_pixel_red : max_level;

   // Table copies, one per read port
   rgl_ram #(.WIDTH(LEVEL_W), .DEPTH(TABLE_DEPTH)) u_ram_red (
      .clock   (clock),
      .wr_en   (tbl_wr),
      .wr_addr (req_entry_index),
      .wr_data (req_entry_level),
      .rd_en   (tbl_rd),
      .rd_addr (addr_red),
      .rd_data (lvl_red)
   );

   rgl_ram #(.WIDTH(LEVEL_W), .DEPTH(TABLE_DEPTH)) u_ram_green (
      .clock   (clock),
      .wr_en   (tbl_wr),
      .wr_addr (req_entry_index),
      .wr_data (req_entry_level),
      .rd_en   (tbl_rd),
      .rd_addr (req_pixel_green),
      .rd_data (lvl_green)
   );

   rgl_ram #(.WIDTH(LEVEL_W), .DEPTH(TABLE_DEPTH)) u_ram_blue (
      .clock   (clock),
      .wr_en   (tbl_wr),
      .wr_addr (req_entry_index),
      .wr_data (req_entry_level),
      .rd_en   (tbl_rd),
      .rd_addr (req_pixel_blue),
      .rd_data (lvl_blue)
   );

   // Stage 1: pixel fields alongside the RAM read
   always_comb begin
      s1_valid_in       = tbl_rd;
      s1_in.per_channel = (mode_ff == MODE_PER_CHANNEL);
      s1_in.red         = req_pixel_red;
      s1_in.green       = req_pixel_green;
      s1_in.blue        = req_pixel_blue;
      s1_in.alpha       = req_pixel_alpha;
      s1_in.max_level   = max_level;
      s1_in.recip       = RECIP_TABLE[max_level];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff <= s1_in;
      end
   end

   rgl_scale u_scale (
      .clock         (clock),
      .reset         (reset),
      .adv           (adv),
      .s1_valid      (s1_valid_ff),
      .s1_pix        (s1_ff),
      .lvl_red       (lvl_red),
      .lvl_green     (lvl_green),
      .lvl_blue      (lvl_blue),
      .rsp_valid     (rsp_valid),
      .rsp_out_red   (rsp_out_red),
      .rsp_out_green (rsp_out_green),
      .rsp_out_blue  (rsp_out_blue),
      .rsp_out_alpha (rsp_out_alpha)
   );

   // Mode only moves on a csr write
   a_mode_stable: assert property (@(posedge clock) disable iff (reset)
      !csr_wr_en |=> $stable(mode_ff))
      else $error("mode changed without csr write");

   // Stage 1 valid tracks exactly the accepted pixel transactions
   a_s1_track: assert property (@(posedge clock) disable iff (reset)
      adv |=> s1_valid_ff == $past(tbl_rd))
      else $error("stage 1 valid out of step with accepted pixels");

   // No table write and pixel read in the same cycle
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(tbl_wr && tbl_rd))
      else $error("table write and read in the same cycle");

endmodule

// ===== rtl/rgl_ram.sv =====
module rgl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/rgl_scale.sv =====
module rgl_scale import rgl_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      adv,
   input  logic      s1_valid,
   input  pix_type   s1_pix,
   input  level_type lvl_red,
   input  level_type lvl_green,
   input  level_type lvl_blue,
   output logic      rsp_valid,
   output level_type rsp_out_red,
   output level_type rsp_out_green,
   output level_type rsp_out_blue,
   output level_type rsp_out_alpha
);

   typedef struct packed {
      logic              per_channel;
      logic              m_zero;
      level_type         level;
      level_type         lvl_green;
      level_type         lvl_blue;
      level_type         red;
      level_type         max_level;
      level_type         alpha;
      logic [PROD_W-1:0] prod_red;
      logic [PROD_W-1:0] prod_green;
      logic [PROD_W-1:0] prod_blue;
      recip_type         recip;
   } s2_type;

   localparam int WIDE_W = PROD_W + RECIP_W;

   logic        s2_valid_ff, s2_valid_in;
   s2_type      s2_ff, s2_in;
   logic        out_valid_ff, out_valid_in;
   level_type   out_red_ff, out_green_ff, out_blue_ff, out_alpha_ff;
   level_type   out_red_in, out_green_in, out_blue_in;
   logic [WIDE_W-1:0] wide_red, wide_green, wide_blue;
   level_type   q_red, q_green, q_blue;

   // Stage 2: channel times corrected level (in value mode lvl_red holds table[m])
   always_comb begin
      s2_valid_in          = s1_valid;
      s2_in.per_channel    = s1_pix.per_channel;
      s2_in.m_zero         = (s1_pix.max_level == '0);
      s2_in.level          = lvl_red;
      s2_in.lvl_green      = lvl_green;
      s2_in.lvl_blue       = lvl_blue;
      s2_in.red            = s1_pix.red;
      s2_in.max_level      = s1_pix.max_level;
      s2_in.alpha          = s1_pix.alpha;
      s2_in.prod_red       = PROD_W'(s1_pix.red)   * PROD_W'(lvl_red);
      s2_in.prod_green     = PROD_W'(s1_pix.green) * PROD_W'(lvl_red);
      s2_in.prod_blue      = PROD_W'(s1_pix.blue)  * PROD_W'(lvl_red);
      s2_in.recip          = s1_pix.recip;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_ff <= s2_in;
      end
   end

   // Stage 3: divide by m through the reciprocal
   assign wide_red   = WIDE_W'(s2_ff.prod_red)   * WIDE_W'(s2_ff.recip);
   assign wide_green = WIDE_W'(s2_ff.prod_green) * WIDE_W'(s2_ff.recip);
   assign wide_blue  = WIDE_W'(s2_ff.prod_blue)  * WIDE_W'(s2_ff.recip);
   assign q_red      = wide_red[RECIP_SHIFT +: LEVEL_W];
   assign q_green    = wide_green[RECIP_SHIFT +: LEVEL_W];
   assign q_blue     = wide_blue[RECIP_SHIFT +: LEVEL_W];

   // Result select
   always_comb begin
      out_valid_in = s2_valid_ff;
      if (s2_ff.per_channel) begin
         out_red_in   = s2_ff.level;
         out_green_in = s2_ff.lvl_green;
         out_blue_in  = s2_ff.lvl_blue;
      end else if (s2_ff.m_zero) begin
         out_red_in   = s2_ff.level;
         out_green_in = s2_ff.level;
         out_blue_in  = s2_ff.level;
      end else begin
         out_red_in   = q_red;
         out_green_in = q_green;
         out_blue_in  = q_blue;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_red_ff   <= out_red_in;
         out_green_ff <= out_green_in;
         out_blue_ff  <= out_blue_in;
         out_alpha_ff <= s2_ff.alpha;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_out_red   = out_red_ff;
   assign rsp_out_green = out_green_ff;
   assign rsp_out_blue  = out_blue_ff;
   assign rsp_out_alpha = out_alpha_ff;

   // Scaled channel never exceeds the corrected level
   a_q_le_level: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && !s2_ff.per_channel && !s2_ff.m_zero
      |-> q_red <= s2_ff.level && q_green <= s2_ff.level && q_blue <= s2_ff.level)
      else $error("value-mode channel above corrected level");

   // Red, when it sets the max, maps exactly to the corrected level
   a_q_max_exact: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && !s2_ff.per_channel && !s2_ff.m_zero && s2_ff.red == s2_ff.max_level
      |-> q_red == s2_ff.level)
      else $error("reciprocal division not exact on max channel");

   // Output register only changes on advance
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(out_red_ff) && $stable(out_alpha_ff) && out_valid_ff)
      else $error("output changed while stalled");

endmodule
